>>> rtl/art_pkg.sv
// Package with the types and constants of the aging route table.
package art_pkg;

	localparam int ADDR_W = 16;
	localparam int TTL_W = 8;
	localparam int COUNT_W = 7;

	localparam logic [1:0] REQ_LEARN = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_AGE = 2'd2;

	localparam logic [TTL_W-1:0] TTL_RESET = 8'd10;

	typedef struct packed {
		logic [1:0] req_type;
		logic [ADDR_W-1:0] dest_addr;
		logic [ADDR_W-1:0] hop_addr;
	} req_t;

	typedef struct packed {
		logic status;
		logic found;
		logic [ADDR_W-1:0] next_hop;
		logic [COUNT_W-1:0] entries_used;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

>>> rtl/art_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module art_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/aging_route_table_unit.sv
// Top level of the aging route table: request sequencer, route memory and result register.
//
// A request transfer on the req channel carries a learn, a lookup or an age tick.
// The block walks the packed route table one entry per cycle through a single RAM
// read port and answers with exactly one transfer on the rsp channel.
// For a lookup or learn that matches entry k, the scan stops at that entry and the
// result is registered after it. A miss, an append, a drop on a full table and an age
// tick walk all N valid routes before the result is registered, and an unused request
// code goes straight from idle to the result. The next request is taken in the cycle
// after the result is registered.
// req_stall is high from acceptance until the result has been placed in the
// output register, so one request is in work at a time; the next request may be
// accepted while that result still waits on a stalled receiver.
// When rsp_stall is high the result holds; a finished request then waits for the
// output register before the block goes idle again.
// The cfg channel writes the reload ttl and is always ready; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Reset empties the table and sets the reload ttl to ten; no clearing pass runs,
// as only entries below the route count are ever read.
module aging_route_table_unit #(
	parameter int TABLE_DEPTH = 64,
	parameter int ADDR_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input art_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output art_pkg::rsp_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [art_pkg::TTL_W-1:0] cfg_data
);

	localparam int AW = (ADDR_BITS < art_pkg::ADDR_W) ? ADDR_BITS : art_pkg::ADDR_W;
	localparam int TW = art_pkg::TTL_W;
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = 2 * AW + TW;

	art_pkg::state_t state_q, state_d;
	logic [TW-1:0] ttl_reload_q;
	logic [1:0] op_q;
	logic [AW-1:0] dest_q, hop_q;
	logic [CW-1:0] used_q, issue_q, wr_q;
	logic pend_q;
	logic [IW-1:0] pidx_q;
	logic res_status_q, res_found_q;
	logic [AW-1:0] res_hop_q;
	logic rsp_valid_q;
	art_pkg::rsp_t rsp_q;

	logic accept, issue, scan_end, hit, ttl_live, out_free, finish;
	logic is_match_op, append, drop, age_wr;
	logic ram_we;
	logic [IW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	logic [AW-1:0] rd_dest, rd_hop;
	logic [TW-1:0] rd_ttl;

	art_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_route_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rd_dest = ram_rdata[EW-1 -: AW];
	assign rd_hop = ram_rdata[TW+AW-1 -: AW];
	assign rd_ttl = ram_rdata[TW-1:0];

	assign accept = req_valid && (state_q == art_pkg::ST_IDLE);
	assign issue = (state_q == art_pkg::ST_SCAN) && (issue_q < used_q);
	assign scan_end = (state_q == art_pkg::ST_SCAN) && !pend_q && !issue;
	assign is_match_op = (op_q == art_pkg::REQ_LEARN) || (op_q == art_pkg::REQ_LOOKUP);
	assign hit = (state_q == art_pkg::ST_SCAN) && pend_q && is_match_op && (rd_dest == dest_q);
	assign ttl_live = rd_ttl > TW'(1);
	assign append = scan_end && (op_q == art_pkg::REQ_LEARN) && (used_q < CW'(TABLE_DEPTH));
	assign drop = scan_end && (op_q == art_pkg::REQ_LEARN) && (used_q >= CW'(TABLE_DEPTH));
	assign age_wr = (state_q == art_pkg::ST_SCAN) && (op_q == art_pkg::REQ_AGE)
		&& pend_q && ttl_live;
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign finish = (state_q == art_pkg::ST_DONE) && out_free;
	assign ram_raddr = issue_q[IW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			art_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req.req_type inside {art_pkg::REQ_LEARN, art_pkg::REQ_LOOKUP,
						art_pkg::REQ_AGE}) begin
						state_d = art_pkg::ST_SCAN;
					end else begin
						state_d = art_pkg::ST_DONE;
					end
				end
			end
			art_pkg::ST_SCAN: begin
				if (hit || scan_end) begin
					state_d = art_pkg::ST_DONE;
				end
			end
			art_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = art_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = art_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = (state_q != art_pkg::ST_IDLE);
		cfg_ready = 1'b1;
		rsp_valid = rsp_valid_q;
		rsp = rsp_q;
		ram_we = 1'b0;
		ram_waddr = wr_q[IW-1:0];
		ram_wdata = {rd_dest, rd_hop, rd_ttl - TW'(1)};
		if (hit && (op_q == art_pkg::REQ_LEARN)) begin
			ram_we = 1'b1;
			ram_waddr = pidx_q;
			ram_wdata = {dest_q, rd_hop, ttl_reload_q};
		end else if (append) begin
			ram_we = 1'b1;
			ram_waddr = used_q[IW-1:0];
			ram_wdata = {dest_q, hop_q, ttl_reload_q};
		end else if (age_wr) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= art_pkg::ST_IDLE;
			ttl_reload_q <= art_pkg::TTL_RESET;
			used_q <= '0;
			issue_q <= '0;
			wr_q <= '0;
			pend_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				ttl_reload_q <= cfg_data;
			end
			pend_q <= issue && (state_d == art_pkg::ST_SCAN);
			if (accept) begin
				issue_q <= '0;
			end else if (issue) begin
				issue_q <= issue_q + CW'(1);
			end
			if (accept) begin
				wr_q <= '0;
			end else if (age_wr) begin
				wr_q <= wr_q + CW'(1);
			end
			if (append) begin
				used_q <= used_q + CW'(1);
			end else if (scan_end && (op_q == art_pkg::REQ_AGE)) begin
				used_q <= wr_q;
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pidx_q <= issue_q[IW-1:0];
		if (accept) begin
			op_q <= req.req_type;
			dest_q <= req.dest_addr[AW-1:0];
			hop_q <= req.hop_addr[AW-1:0];
			res_status_q <= 1'b0;
			res_found_q <= 1'b0;
			res_hop_q <= '0;
		end else begin
			if (hit) begin
				res_found_q <= 1'b1;
				res_hop_q <= rd_hop;
			end
			if (drop) begin
				res_status_q <= 1'b1;
			end
		end
		if (finish) begin
			rsp_q.status <= res_status_q;
			rsp_q.found <= res_found_q;
			rsp_q.next_hop <= art_pkg::ADDR_W'(res_hop_q);
			rsp_q.entries_used <= art_pkg::COUNT_W'(used_q);
		end
	end

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(TABLE_DEPTH))
		else $error("route count exceeds the table depth");

	a_drop_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == art_pkg::ST_DONE) && res_status_q |-> used_q == CW'(TABLE_DEPTH))
		else $error("learn dropped while the table has room");

	a_read_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> $past(state_q == art_pkg::ST_SCAN))
		else $error("read data pending outside a scan");

	a_found_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == art_pkg::ST_DONE) && res_found_q |-> !res_status_q)
		else $error("matched request also flagged as dropped");

endmodule
